/* design/rmv_pkg.sv */
// ----------------------------------------------------------------------------
// rmv_pkg: shared types and constants for the running mean and variance block
// Field widths, saturation limits, step counts of the shared divide and square
// root unit, and the operation struct that starts that unit.
// ----------------------------------------------------------------------------
package rmv_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int COUNT_WIDTH  = 16;
  localparam int VAR_WIDTH    = 49;
  localparam int STD_WIDTH    = 25;
  localparam int SUM_WIDTH    = 64;
  localparam int MAG_WIDTH    = SAMPLE_WIDTH + 1;
  localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH + 1;
  localparam int STEP_WIDTH   = 7;
  localparam int REM_WIDTH    = 26;
  localparam int SUB_WIDTH    = 28;

  localparam logic [COUNT_WIDTH-1:0] COUNT_CAP = 16'hFFFF;
  localparam logic [VAR_WIDTH-1:0]   VAR_MAX   = {VAR_WIDTH{1'b1}};

  localparam logic MODE_DIV  = 1'b0;
  localparam logic MODE_SQRT = 1'b1;

  localparam logic [STEP_WIDTH-1:0] MEAN_DIV_STEPS = 7'd25;
  localparam logic [STEP_WIDTH-1:0] VAR_DIV_STEPS  = 7'd64;
  localparam logic [STEP_WIDTH-1:0] SQRT_STEPS     = 7'd25;

  typedef struct packed {
    logic                  start;
    logic                  mode;
    logic [STEP_WIDTH-1:0] steps;
  } rmv_op_t;

endpackage

/* design/rmv_if.sv */
// ----------------------------------------------------------------------------
// rmv_if: valid/ready channels of the running mean and variance block
// One interface carries sample words in, the other carries statistics words
// out. A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface rmv_in_if;
  import rmv_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           start_new;

  modport source (output valid, output sample, output start_new, input ready);
  modport sink (input valid, input sample, input start_new, output ready);
endinterface

interface rmv_out_if;
  import rmv_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [COUNT_WIDTH-1:0]         sample_count;
  logic signed [SAMPLE_WIDTH-1:0] mean;
  logic [VAR_WIDTH-1:0]           variance;
  logic [STD_WIDTH-1:0]           std_dev;
  logic signed [SAMPLE_WIDTH-1:0] minimum;
  logic signed [SAMPLE_WIDTH-1:0] maximum;
  logic                           dropped;

  modport source (output valid, output sample_count, output mean, output variance,
                  output std_dev, output minimum, output maximum, output dropped,
                  input ready);
  modport sink (input valid, input sample_count, input mean, input variance,
                input std_dev, input minimum, input maximum, input dropped,
                output ready);
endinterface

/* design/running_mean_variance.sv */
// ----------------------------------------------------------------------------
// running_mean_variance: running count, mean, variance, deviation, min, max
// Welford update of mean and squared-deviation sum per sample, with the
// divides and the square root done on one shared iterative unit.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word contents
//  --------+-----------+---------------------------------------------------
//  samples | in        | sample, start_new
//  stats   | out       | sample_count, mean, variance, std_dev, minimum,
//          |           | maximum, dropped
//
// A sample that extends a set runs through the mean divide, the variance
// divide and the square root on the shared unit in that order, with
// sequencing states between them, before its statistics word is loaded.
// The first sample of a set and a dropped sample skip the shared unit.
// Synchronous reset clears the statistics and empties the output register.
// A stalled output holds the next sample off only once its word is ready.
// ----------------------------------------------------------------------------
module running_mean_variance (
  input  logic clk,
  input  logic rst,
  rmv_in_if.sink    samples,
  rmv_out_if.source stats
);
  import rmv_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MEAN_GO   = 4'd1;
  localparam logic [3:0] S_MEAN_WAIT = 4'd2;
  localparam logic [3:0] S_DEV       = 4'd3;
  localparam logic [3:0] S_MUL       = 4'd4;
  localparam logic [3:0] S_ACC       = 4'd5;
  localparam logic [3:0] S_VAR_GO    = 4'd6;
  localparam logic [3:0] S_VAR_WAIT  = 4'd7;
  localparam logic [3:0] S_SQRT_GO   = 4'd8;
  localparam logic [3:0] S_SQRT_WAIT = 4'd9;
  localparam logic [3:0] S_EMIT      = 4'd10;

  logic [3:0]                     state;
  logic [COUNT_WIDTH-1:0]         count;
  logic signed [SAMPLE_WIDTH-1:0] mean;
  logic [SUM_WIDTH-1:0]           sum;
  logic signed [SAMPLE_WIDTH-1:0] min_v;
  logic signed [SAMPLE_WIDTH-1:0] max_v;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic [MAG_WIDTH-1:0]           a_mag;
  logic                           d_neg;
  logic [MAG_WIDTH-1:0]           b_mag;
  logic [PROD_WIDTH-1:0]          prod;
  logic [VAR_WIDTH-1:0]           var_v;
  logic [STD_WIDTH-1:0]           std_v;
  logic                           drop_v;

  logic                           accept;
  logic [COUNT_WIDTH-1:0]         cnt_eff;
  logic signed [MAG_WIDTH-1:0]    delta;
  logic signed [MAG_WIDTH-1:0]    dev;
  logic signed [MAG_WIDTH:0]      q_s;
  logic signed [MAG_WIDTH:0]      mean_sum;
  logic [SUM_WIDTH:0]             sum_add;
  logic                           emit_load;

  rmv_op_t                        op;
  logic [SUM_WIDTH-1:0]           operand;
  logic [COUNT_WIDTH-1:0]         divisor;
  logic                           unit_done;
  logic [SUM_WIDTH-1:0]           quotient;
  logic [STD_WIDTH-1:0]           root;

  assign samples.ready = (state == S_IDLE) && !rst;
  assign accept        = samples.valid && samples.ready;
  assign cnt_eff       = samples.start_new ? '0 : count;
  assign emit_load     = (state == S_EMIT) && (!stats.valid || stats.ready);

  always_comb begin
    delta    = MAG_WIDTH'(samples.sample) - MAG_WIDTH'(mean);
    dev      = MAG_WIDTH'(x) - MAG_WIDTH'(mean);
    q_s      = d_neg ? -$signed({1'b0, quotient[MAG_WIDTH-1:0]})
                     : $signed({1'b0, quotient[MAG_WIDTH-1:0]});
    mean_sum = (MAG_WIDTH+1)'(mean) + q_s;
    sum_add  = {1'b0, sum} + {{(SUM_WIDTH+1-PROD_WIDTH){1'b0}}, prod};
  end

  always_comb begin
    op.start = 1'b0;
    op.mode  = MODE_DIV;
    op.steps = MEAN_DIV_STEPS;
    operand  = {a_mag, {(SUM_WIDTH-MAG_WIDTH){1'b0}}};
    divisor  = count;
    unique case (state)
      S_MEAN_GO: begin
        op.start = 1'b1;
      end
      S_VAR_GO: begin
        op.start = 1'b1;
        op.steps = VAR_DIV_STEPS;
        operand  = sum;
        divisor  = count - COUNT_WIDTH'(1);
      end
      S_SQRT_GO: begin
        op.start = 1'b1;
        op.mode  = MODE_SQRT;
        op.steps = SQRT_STEPS;
        operand  = {1'b0, var_v, {(SUM_WIDTH-VAR_WIDTH-1){1'b0}}};
      end
      default: begin
      end
    endcase
  end

  rmv_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .operand  (operand),
    .divisor  (divisor),
    .done     (unit_done),
    .quotient (quotient),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      mean  <= '0;
      sum   <= '0;
      min_v <= '0;
      max_v <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cnt_eff == COUNT_CAP) begin
              state <= S_EMIT;
            end else if (cnt_eff == '0) begin
              count <= COUNT_WIDTH'(1);
              mean  <= samples.sample;
              sum   <= '0;
              min_v <= samples.sample;
              max_v <= samples.sample;
              state <= S_EMIT;
            end else begin
              count <= count + COUNT_WIDTH'(1);
              if (samples.sample < min_v) begin
                min_v <= samples.sample;
              end
              if (samples.sample > max_v) begin
                max_v <= samples.sample;
              end
              state <= S_MEAN_GO;
            end
          end
        end
        S_MEAN_GO: begin
          state <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (unit_done) begin
            mean  <= mean_sum[SAMPLE_WIDTH-1:0];
            state <= S_DEV;
          end
        end
        S_DEV: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          sum   <= sum_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_add[SUM_WIDTH-1:0];
          state <= S_VAR_GO;
        end
        S_VAR_GO: begin
          state <= S_VAR_WAIT;
        end
        S_VAR_WAIT: begin
          if (unit_done) begin
            state <= S_SQRT_GO;
          end
        end
        S_SQRT_GO: begin
          state <= S_SQRT_WAIT;
        end
        S_SQRT_WAIT: begin
          if (unit_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x      <= samples.sample;
      a_mag  <= delta[MAG_WIDTH-1] ? -delta : delta;
      d_neg  <= delta[MAG_WIDTH-1];
      drop_v <= (cnt_eff == COUNT_CAP);
      if (cnt_eff == '0) begin
        var_v <= '0;
        std_v <= '0;
      end
    end
    if (state == S_DEV) begin
      b_mag <= dev[MAG_WIDTH-1] ? -dev : dev;
    end
    if (state == S_MUL) begin
      prod <= PROD_WIDTH'(a_mag * b_mag);
    end
    if (state == S_VAR_WAIT && unit_done) begin
      var_v <= (|quotient[SUM_WIDTH-1:VAR_WIDTH]) ? VAR_MAX : quotient[VAR_WIDTH-1:0];
    end
    if (state == S_SQRT_WAIT && unit_done) begin
      std_v <= root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats.valid <= 1'b0;
    end else if (emit_load) begin
      stats.valid <= 1'b1;
    end else if (stats.ready) begin
      stats.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      stats.sample_count <= count;
      stats.mean         <= mean;
      stats.variance     <= var_v;
      stats.std_dev      <= std_v;
      stats.minimum      <= min_v;
      stats.maximum      <= max_v;
      stats.dropped      <= drop_v;
    end
  end

endmodule

/* design/rmv_divsqrt.sv */
// ----------------------------------------------------------------------------
// rmv_divsqrt: shared iterative divide and square root unit
// One compare-subtract datapath serves both a restoring divider (one quotient
// bit per cycle) and a digit-by-digit square root (one root bit per cycle).
// ----------------------------------------------------------------------------
module rmv_divsqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  rmv_pkg::rmv_op_t                   op,
  input  logic [rmv_pkg::SUM_WIDTH-1:0]      operand,
  input  logic [rmv_pkg::COUNT_WIDTH-1:0]    divisor,
  output logic                               done,
  output logic [rmv_pkg::SUM_WIDTH-1:0]      quotient,
  output logic [rmv_pkg::STD_WIDTH-1:0]      root
);
  import rmv_pkg::*;

  logic                   busy;
  logic [STEP_WIDTH-1:0]  steps_left;
  logic                   mode;
  logic [SUM_WIDTH-1:0]   dq;
  logic [REM_WIDTH-1:0]   rem;
  logic [COUNT_WIDTH-1:0] dvs;
  logic [STD_WIDTH-1:0]   rt;
  logic [SUB_WIDTH-1:0]   sub_a;
  logic [SUB_WIDTH-1:0]   sub_b;
  logic [SUB_WIDTH:0]     diff;
  logic                   ge;

  always_comb begin
    if (mode == MODE_SQRT) begin
      sub_a = {rem, dq[SUM_WIDTH-1 -: 2]};
      sub_b = {1'b0, rt, 2'b01};
    end else begin
      sub_a = {{(SUB_WIDTH-COUNT_WIDTH-1){1'b0}}, rem[COUNT_WIDTH-1:0], dq[SUM_WIDTH-1]};
      sub_b = {{(SUB_WIDTH-COUNT_WIDTH){1'b0}}, dvs};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[SUB_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (op.start) begin
        busy <= 1'b1;
      end else if (busy && steps_left == STEP_WIDTH'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.start) begin
      steps_left <= op.steps;
      mode       <= op.mode;
      dq         <= operand;
      dvs        <= divisor;
      rem        <= '0;
      rt         <= '0;
    end else if (busy) begin
      steps_left <= steps_left - STEP_WIDTH'(1);
      rem        <= ge ? diff[REM_WIDTH-1:0] : sub_a[REM_WIDTH-1:0];
      if (mode == MODE_SQRT) begin
        dq <= {dq[SUM_WIDTH-3:0], 2'b00};
        rt <= {rt[STD_WIDTH-2:0], ge};
      end else begin
        dq <= {dq[SUM_WIDTH-2:0], ge};
      end
    end
  end

  assign quotient = dq;
  assign root     = rt;

endmodule

/* design/rmv_checker.sv */
// ----------------------------------------------------------------------------
// rmv_checker: port-level checks for the running mean and variance block
// Watches both channels and the statistics words over time.
// ----------------------------------------------------------------------------
module rmv_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [rmv_pkg::COUNT_WIDTH-1:0]     sample_count,
  input logic signed [rmv_pkg::SAMPLE_WIDTH-1:0] mean,
  input logic [rmv_pkg::VAR_WIDTH-1:0]       variance,
  input logic [rmv_pkg::STD_WIDTH-1:0]       std_dev,
  input logic signed [rmv_pkg::SAMPLE_WIDTH-1:0] minimum,
  input logic signed [rmv_pkg::SAMPLE_WIDTH-1:0] maximum,
  input logic                                dropped
);
  import rmv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(variance) && $stable(sample_count))
    else $error("stats word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while previous word still in work");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> sample_count == COUNT_CAP)
    else $error("drop reported below the count limit");

  a_short_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count < COUNT_WIDTH'(2) |-> variance == '0 && std_dev == '0)
    else $error("nonzero spread with fewer than two samples");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count == COUNT_WIDTH'(1) |-> minimum == mean && maximum == mean)
    else $error("single sample set with differing mean, minimum or maximum");

endmodule

bind running_mean_variance rmv_checker u_rmv_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .out_valid    (stats.valid),
  .out_ready    (stats.ready),
  .sample_count (stats.sample_count),
  .mean         (stats.mean),
  .variance     (stats.variance),
  .std_dev      (stats.std_dev),
  .minimum      (stats.minimum),
  .maximum      (stats.maximum),
  .dropped      (stats.dropped)
);
